// ----- rtl/cdmc_pkg.sv -----
// ---------------------------------------------------------------------------
// cdmc_pkg: shared types and constants of the clock display mode controller
// Mode encoding, page and separator codes, item and result records.
// ---------------------------------------------------------------------------
`default_nettype none

package cdmc_pkg;

    // One-hot mode register
    typedef enum logic [10:0] {
        MODE_STARTUP    = 11'b000_0000_0001,
        MODE_TIME       = 11'b000_0000_0010,
        MODE_YEAR       = 11'b000_0000_0100,
        MODE_DATE       = 11'b000_0000_1000,
        MODE_WEEK       = 11'b000_0001_0000,
        MODE_BLANK      = 11'b000_0010_0000,
        MODE_SET_HOUR   = 11'b000_0100_0000,
        MODE_SET_MINUTE = 11'b000_1000_0000,
        MODE_SET_YEAR   = 11'b001_0000_0000,
        MODE_SET_MONTH  = 11'b010_0000_0000,
        MODE_SET_DAY    = 11'b100_0000_0000
    } mode_t;

    // Page codes as shown on the result channel
    localparam logic [3:0] PAGE_STARTUP    = 4'd0;
    localparam logic [3:0] PAGE_TIME       = 4'd1;
    localparam logic [3:0] PAGE_YEAR       = 4'd2;
    localparam logic [3:0] PAGE_DATE       = 4'd3;
    localparam logic [3:0] PAGE_WEEK       = 4'd4;
    localparam logic [3:0] PAGE_BLANK      = 4'd5;
    localparam logic [3:0] PAGE_SET_HOUR   = 4'd6;
    localparam logic [3:0] PAGE_SET_MINUTE = 4'd7;
    localparam logic [3:0] PAGE_SET_YEAR   = 4'd8;
    localparam logic [3:0] PAGE_SET_MONTH  = 4'd9;
    localparam logic [3:0] PAGE_SET_DAY    = 4'd10;

    // Middle character
    localparam logic [1:0] SEP_BLANK = 2'd0;
    localparam logic [1:0] SEP_COLON = 2'd1;
    localparam logic [1:0] SEP_DASH  = 2'd2;

    // Command kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_UI   = 1'b1;

    // Field bounds (7-bit to share one adjust function)
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINUTE_MAX = 7'd59;
    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] DAY_MAX    = 7'd31;
    localparam logic [6:0] FIELD_ZERO = 7'd0;
    localparam logic [6:0] FIELD_ONE  = 7'd1;

    // Page rotation points on the seconds value
    localparam logic [5:0] SEC_TO_YEAR = 6'd5;
    localparam logic [5:0] SEC_TO_DATE = 6'd10;
    localparam logic [5:0] SEC_TO_WEEK = 6'd15;
    localparam logic [5:0] SEC_TO_TIME = 6'd20;

    localparam logic [14:0] STARTUP_TICKS_RST = 15'd20000;

    typedef struct packed {
        logic       cmd;
        logic       key_set;
        logic       key_plus;
        logic       key_minus;
        logic [4:0] rtc_hour;
        logic [5:0] rtc_minute;
        logic [5:0] rtc_second;
        logic [6:0] rtc_year;
        logic [3:0] rtc_month;
        logic [4:0] rtc_day;
        logic [2:0] rtc_week;
    } in_item_t;

    typedef struct packed {
        logic [3:0] page;
        logic [4:0] show_hour;
        logic [5:0] show_minute;
        logic [6:0] show_year;
        logic [3:0] show_month;
        logic [4:0] show_day;
        logic [2:0] show_week;
        logic [1:0] separator;
        logic       highlight_left;
        logic       highlight_right;
        logic       rtc_write;
    } result_t;

    function automatic logic [3:0] page_of(mode_t m);
        logic [3:0] p;
        begin
            case (m)
                MODE_STARTUP:    p = PAGE_STARTUP;
                MODE_TIME:       p = PAGE_TIME;
                MODE_YEAR:       p = PAGE_YEAR;
                MODE_DATE:       p = PAGE_DATE;
                MODE_WEEK:       p = PAGE_WEEK;
                MODE_BLANK:      p = PAGE_BLANK;
                MODE_SET_HOUR:   p = PAGE_SET_HOUR;
                MODE_SET_MINUTE: p = PAGE_SET_MINUTE;
                MODE_SET_YEAR:   p = PAGE_SET_YEAR;
                MODE_SET_MONTH:  p = PAGE_SET_MONTH;
                MODE_SET_DAY:    p = PAGE_SET_DAY;
                default:         p = PAGE_STARTUP;
            endcase
            return p;
        end
    endfunction

    // Step up below hi, then step down above lo
    function automatic logic [6:0] adjust(logic [6:0] v, logic up, logic down,
                                          logic [6:0] lo, logic [6:0] hi);
        logic [6:0] t;
        begin
            t = v;
            if (up && (t < hi))
            begin
                t = t + 7'd1;
            end
            if (down && (t > lo))
            begin
                t = t - 7'd1;
            end
            return t;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/clock_display_mode_controller_top.sv -----
// ---------------------------------------------------------------------------
// clock_display_mode_controller_top: page and edit controller of a digit clock
// Path: an accepted item is registered in the input reg, then its result in the
//   result reg; m_tvalid rises when the result reg is loaded.
// Throughput: one item per cycle while m_tready is high; one short update pass.
//   A held result stalls the input register (m_tready gates s_tready directly).
// Reset (rst_n low, async): startup page, count = startup_ticks = 20000,
//   held values cleared (month and day to 1), both stages empty.
// ---------------------------------------------------------------------------
`default_nettype none

module clock_display_mode_controller_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata, low bit up: key_set, key_plus, key_minus, rtc_hour[4:0],
    // rtc_minute[5:0], rtc_second[5:0], rtc_year[6:0], rtc_month[3:0],
    // rtc_day[4:0], rtc_week[2:0], pad
    input  wire logic [39:0] s_tdata,
    // tuser: cmd (0 tick, 1 UI step)
    input  wire logic        s_tuser,
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata, low bit up: page[3:0], show_hour[4:0], show_minute[5:0],
    // show_year[6:0], show_month[3:0], show_day[4:0], show_week[2:0],
    // separator[1:0], highlight_left, highlight_right, rtc_write, pad
    output logic [39:0]      m_tdata,
    // configuration: startup_ticks
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [14:0] cfg_data
);
    import cdmc_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_free;
    logic     step;
    result_t  res;
    result_t  res_q;

    // unpack the slave transfer
    assign s_item.cmd        = s_tuser;
    assign s_item.key_set    = s_tdata[0];
    assign s_item.key_plus   = s_tdata[1];
    assign s_item.key_minus  = s_tdata[2];
    assign s_item.rtc_hour   = s_tdata[7:3];
    assign s_item.rtc_minute = s_tdata[13:8];
    assign s_item.rtc_second = s_tdata[19:14];
    assign s_item.rtc_year   = s_tdata[26:20];
    assign s_item.rtc_month  = s_tdata[30:27];
    assign s_item.rtc_day    = s_tdata[35:31];
    assign s_item.rtc_week   = s_tdata[38:36];

    // item moves into the core when the result register can take it
    assign step = item_valid && out_free;

    // config must be written only while idle (the block does not enforce it); no back-pressure needed
    assign cfg_ready = 1'b1;

    cdmc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .consume    (step),
        .item_valid (item_valid),
        .item       (item)
    );

    cdmc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .res      (res)
    );

    cdmc_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (step),
        .res_in  (res),
        .free    (out_free),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .res_out (res_q)
    );

    // pack the master transfer
    assign m_tdata[3:0]   = res_q.page;
    assign m_tdata[8:4]   = res_q.show_hour;
    assign m_tdata[14:9]  = res_q.show_minute;
    assign m_tdata[21:15] = res_q.show_year;
    assign m_tdata[25:22] = res_q.show_month;
    assign m_tdata[30:26] = res_q.show_day;
    assign m_tdata[33:31] = res_q.show_week;
    assign m_tdata[35:34] = res_q.separator;
    assign m_tdata[36]    = res_q.highlight_left;
    assign m_tdata[37]    = res_q.highlight_right;
    assign m_tdata[38]    = res_q.rtc_write;
    assign m_tdata[39]    = 1'b0;

endmodule

`default_nettype wire

// ----- rtl/cdmc_in_stage.sv -----
// ---------------------------------------------------------------------------
// cdmc_in_stage: input register
// Holds one accepted item until the core consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module cdmc_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cdmc_pkg::in_item_t s_item,
    input  wire logic              consume,
    output logic                   item_valid,
    output cdmc_pkg::in_item_t     item
);
    import cdmc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || consume;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- rtl/cdmc_core.sv -----
// ---------------------------------------------------------------------------
// cdmc_core: mode state and held values
// Next-state logic for ticks and UI steps; builds the result of each step.
// ---------------------------------------------------------------------------
`default_nettype none

module cdmc_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire cdmc_pkg::in_item_t item,
    input  wire logic               cfg_we,
    input  wire logic [14:0]        cfg_data,
    output cdmc_pkg::result_t       res
);
    import cdmc_pkg::*;

    mode_t       mode_reg,   mode_next;
    logic [14:0] ticks_reg;
    logic [14:0] count_reg,  count_next;
    logic [4:0]  hour_reg,   hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [6:0]  year_reg,   year_next;
    logic [3:0]  month_reg,  month_next;
    logic [4:0]  day_reg,    day_next;
    logic [2:0]  week_reg,   week_next;
    logic        inv_l_reg,  inv_l_next;
    logic        inv_r_reg,  inv_r_next;
    logic [1:0]  sep;
    logic        wr;
    logic        editing;

    assign editing = (mode_reg == MODE_SET_HOUR) || (mode_reg == MODE_SET_MINUTE) ||
                     (mode_reg == MODE_SET_YEAR) || (mode_reg == MODE_SET_MONTH) ||
                     (mode_reg == MODE_SET_DAY);

    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        week_next   = week_reg;
        inv_l_next  = inv_l_reg;
        inv_r_next  = inv_r_reg;
        sep         = SEP_BLANK;
        wr          = 1'b0;

        if (item.cmd == CMD_TICK)
        begin
            if ((count_reg != 15'd0) && (mode_reg == MODE_STARTUP))
            begin
                count_next = count_reg - 15'd1;
            end
        end
        else
        begin
            if (!editing)
            begin
                hour_next   = item.rtc_hour;
                minute_next = item.rtc_minute;
                second_next = item.rtc_second;
                year_next   = item.rtc_year;
                month_next  = item.rtc_month;
                day_next    = item.rtc_day;
                week_next   = item.rtc_week;
            end

            case (mode_reg)
                MODE_STARTUP:
                begin
                    if (count_reg == 15'd0)
                    begin
                        mode_next = MODE_TIME;
                    end
                end
                MODE_TIME, MODE_YEAR, MODE_DATE, MODE_WEEK:
                begin
                    if (item.key_set)
                    begin
                        mode_next = MODE_SET_YEAR;
                    end
                    if (item.key_minus)
                    begin
                        mode_next = MODE_BLANK;
                    end
                    // seconds rotation overrides the keys
                    if (mode_reg == MODE_TIME)
                    begin
                        if (second_next == SEC_TO_YEAR)
                        begin
                            mode_next = MODE_YEAR;
                        end
                        sep = (!second_next[0] && (mode_next == MODE_TIME)) ?
                              SEP_COLON : SEP_BLANK;
                    end
                    else if (mode_reg == MODE_YEAR)
                    begin
                        if (second_next == SEC_TO_DATE)
                        begin
                            mode_next = MODE_DATE;
                        end
                    end
                    else if (mode_reg == MODE_DATE)
                    begin
                        if (second_next == SEC_TO_WEEK)
                        begin
                            mode_next = MODE_WEEK;
                        end
                        sep = SEP_DASH;
                    end
                    else
                    begin
                        if (second_next == SEC_TO_TIME)
                        begin
                            mode_next = MODE_TIME;
                        end
                    end
                end
                MODE_BLANK:
                begin
                    if (item.key_plus)
                    begin
                        mode_next = MODE_TIME;
                    end
                end
                MODE_SET_HOUR:
                begin
                    sep        = SEP_COLON;
                    inv_l_next = !item.key_set;
                    if (item.key_set)
                    begin
                        mode_next = MODE_SET_MINUTE;
                    end
                    hour_next = 5'(adjust({2'b00, hour_reg}, item.key_plus, item.key_minus,
                                          FIELD_ZERO, HOUR_MAX));
                end
                MODE_SET_MINUTE:
                begin
                    sep        = SEP_COLON;
                    inv_r_next = !item.key_set;
                    if (item.key_set)
                    begin
                        second_next = 6'd0;
                        wr          = 1'b1;
                        mode_next   = MODE_TIME;
                    end
                    else
                    begin
                        minute_next = 6'(adjust({1'b0, minute_reg}, item.key_plus,
                                                item.key_minus, FIELD_ZERO, MINUTE_MAX));
                    end
                end
                MODE_SET_YEAR:
                begin
                    inv_r_next = !item.key_set;
                    if (item.key_set)
                    begin
                        mode_next = MODE_SET_MONTH;
                    end
                    year_next = adjust(year_reg, item.key_plus, item.key_minus,
                                       FIELD_ZERO, YEAR_MAX);
                end
                MODE_SET_MONTH:
                begin
                    sep        = SEP_DASH;
                    inv_l_next = !item.key_set;
                    if (item.key_set)
                    begin
                        mode_next = MODE_SET_DAY;
                    end
                    month_next = 4'(adjust({3'b000, month_reg}, item.key_plus,
                                           item.key_minus, FIELD_ONE, MONTH_MAX));
                end
                MODE_SET_DAY:
                begin
                    sep        = SEP_DASH;
                    inv_r_next = !item.key_set;
                    if (item.key_set)
                    begin
                        mode_next = MODE_SET_HOUR;
                    end
                    day_next = 5'(adjust({2'b00, day_reg}, item.key_plus, item.key_minus,
                                         FIELD_ONE, DAY_MAX));
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_STARTUP;
            ticks_reg  <= STARTUP_TICKS_RST;
            count_reg  <= STARTUP_TICKS_RST;
            hour_reg   <= 5'd0;
            minute_reg <= 6'd0;
            second_reg <= 6'd0;
            year_reg   <= 7'd0;
            month_reg  <= 4'd1;
            day_reg    <= 5'd1;
            week_reg   <= 3'd0;
            inv_l_reg  <= 1'b0;
            inv_r_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ticks_reg <= cfg_data;
                count_reg <= cfg_data;
            end
            else if (step)
            begin
                count_reg <= count_next;
            end
            if (step)
            begin
                mode_reg   <= mode_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                week_reg   <= week_next;
                inv_l_reg  <= inv_l_next;
                inv_r_reg  <= inv_r_next;
            end
        end
    end

    always_comb
    begin
        res.page            = page_of(mode_next);
        res.show_hour       = hour_next;
        res.show_minute     = minute_next;
        res.show_year       = year_next;
        res.show_month      = month_next;
        res.show_day        = day_next;
        res.show_week       = week_next;
        res.separator       = sep;
        res.highlight_left  = inv_l_next;
        res.highlight_right = inv_r_next;
        res.rtc_write       = wr;
    end

    // mode only moves on a UI step
    a_mode_ui_only: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && (item.cmd == CMD_UI)) |=> $stable(mode_reg))
        else $error("mode changed without a UI step");

    // start-up counter only moves on a tick or a register write
    a_count_src: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && (item.cmd == CMD_TICK)) && !cfg_we |=> $stable(count_reg))
        else $error("startup counter changed without a tick");

    // a clock write leaves the time page with seconds cleared
    a_write_exit: assert property (@(posedge clk) disable iff (!rst_n)
        step && wr |=> (mode_reg == MODE_TIME) && (second_reg == 6'd0))
        else $error("clock write without leaving minute edit");

    // the register copy follows every write
    a_ticks_load: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (ticks_reg == $past(cfg_data)))
        else $error("startup_ticks not loaded");

endmodule

`default_nettype wire

// ----- rtl/cdmc_out_stage.sv -----
// ---------------------------------------------------------------------------
// cdmc_out_stage: result register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module cdmc_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire cdmc_pkg::result_t res_in,
    output logic                   free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cdmc_pkg::result_t      res_out
);
    import cdmc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

// ----- sim/clock_display_mode_controller_top_test.sv -----
// ---------------------------------------------------------------------------
// clock_display_mode_controller_top_test: self-checking bench for the display
// mode controller
// A stream driver and a result monitor run around a behavioral model of the
// page and edit logic. Directed steps cover the start-up countdown, the page
// rotation, the blank page and a full edit pass with out-of-range readings.
// Random steps follow, mostly full edit passes with random key traffic.
// Both stream sides stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module clock_display_mode_controller_top_test;

    import cdmc_pkg::*;

    localparam int SETTLE      = 4;       // above the pipeline latency
    localparam int CYCLE_LIMIT = 400000;  // far above the slowest correct run
    localparam int CHUNK_ITEMS = 375;     // random items per register setting
    localparam int IDLE_PCT    = 13;

    // One queued operation: either a stream item or a register write
    typedef struct {
        bit          is_cfg;
        logic [14:0] cfg_val;
        in_item_t    item;
    } op_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (every input known from time zero)
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    wire logic   cfg_ready;
    logic [14:0] cfg_data = '0;

    always #10 clk = ~clk;

    clock_display_mode_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    op_t      pending[$];       // stimulus not yet driven
    result_t  shown_due[$];     // predicted displays, oldest first
    in_item_t cur_item;         // item currently on the slave bus
    logic     s_taken = 1'b0;   // slave transfer at the last rising edge
    logic     cfg_taken = 1'b0; // register write at the last rising edge
    int       quiet = 0;        // rising edges with nothing in flight
    int       cycle_count = 0;
    int       mismatches = 0;
    int       item_count = 0;
    bit       calm;             // stretch with no idling on either side

    // ------------------------------------------------------------------
    // Display model: page/mode, start-up countdown, held reading, highlights
    // ------------------------------------------------------------------
    logic [14:0] boot_left = STARTUP_TICKS_RST;
    logic [3:0]  pg = PAGE_STARTUP;
    logic [4:0]  hh = '0;
    logic [5:0]  mi = '0;
    logic [5:0]  ss = '0;
    logic [6:0]  yy = '0;
    logic [3:0]  mo = 4'd1;
    logic [4:0]  dd = 5'd1;
    logic [2:0]  wk = '0;
    logic        inv_l = 1'b0;
    logic        inv_r = 1'b0;

    // plus first (only below hi), then minus (only above lo)
    function automatic int bump(int v, logic up, logic dn, int lo, int hi);
        int t;
        t = v;
        if (up && t < hi)
            t = t + 1;
        if (dn && t > lo)
            t = t - 1;
        return t;
    endfunction

    function automatic bit in_edit(logic [3:0] p);
        return p >= PAGE_SET_HOUR && p <= PAGE_SET_DAY;
    endfunction

    // Advance the model by one step and return the display it shows
    function automatic result_t next_display(in_item_t it);
        result_t    r;
        logic [3:0] from;
        logic [1:0] sep;
        logic       wr;
        sep = SEP_BLANK;
        wr  = 1'b0;
        if (it.cmd == CMD_TICK)
        begin
            // countdown only runs while the start-up screen is up
            if (boot_left != 0 && pg == PAGE_STARTUP)
                boot_left = boot_left - 15'd1;
        end
        else
        begin
            // the clock reading is frozen while a field is being edited
            if (!in_edit(pg))
            begin
                hh = it.rtc_hour;
                mi = it.rtc_minute;
                ss = it.rtc_second;
                yy = it.rtc_year;
                mo = it.rtc_month;
                dd = it.rtc_day;
                wk = it.rtc_week;
            end
            from = pg;
            case (pg)
                PAGE_STARTUP:
                begin
                    if (boot_left == 0)
                        pg = PAGE_TIME;
                end
                PAGE_TIME, PAGE_YEAR, PAGE_DATE, PAGE_WEEK:
                begin
                    // keys first, minus wins, then the seconds rule overrides
                    if (it.key_set)
                        pg = PAGE_SET_YEAR;
                    if (it.key_minus)
                        pg = PAGE_BLANK;
                    case (from)
                        PAGE_TIME:
                        begin
                            if (ss == SEC_TO_YEAR)
                                pg = PAGE_YEAR;
                            sep = (!ss[0] && pg == PAGE_TIME) ? SEP_COLON : SEP_BLANK;
                        end
                        PAGE_YEAR:
                        begin
                            if (ss == SEC_TO_DATE)
                                pg = PAGE_DATE;
                        end
                        PAGE_DATE:
                        begin
                            if (ss == SEC_TO_WEEK)
                                pg = PAGE_WEEK;
                            sep = SEP_DASH;
                        end
                        default:
                        begin
                            if (ss == SEC_TO_TIME)
                                pg = PAGE_TIME;
                        end
                    endcase
                end
                PAGE_BLANK:
                begin
                    if (it.key_plus)
                        pg = PAGE_TIME;
                end
                PAGE_SET_HOUR:
                begin
                    sep   = SEP_COLON;
                    inv_l = 1'b1;
                    if (it.key_set)
                    begin
                        inv_l = 1'b0;
                        pg    = PAGE_SET_MINUTE;
                    end
                    hh = 5'(bump(hh, it.key_plus, it.key_minus, FIELD_ZERO, HOUR_MAX));
                end
                PAGE_SET_MINUTE:
                begin
                    sep   = SEP_COLON;
                    inv_r = 1'b1;
                    if (it.key_set)
                    begin
                        // leaving edit: write the held time, keys ignored
                        inv_r = 1'b0;
                        ss    = '0;
                        wr    = 1'b1;
                        pg    = PAGE_TIME;
                    end
                    else
                        mi = 6'(bump(mi, it.key_plus, it.key_minus, FIELD_ZERO, MINUTE_MAX));
                end
                PAGE_SET_YEAR:
                begin
                    inv_r = 1'b1;
                    if (it.key_set)
                    begin
                        inv_r = 1'b0;
                        pg    = PAGE_SET_MONTH;
                    end
                    yy = 7'(bump(yy, it.key_plus, it.key_minus, FIELD_ZERO, YEAR_MAX));
                end
                PAGE_SET_MONTH:
                begin
                    sep   = SEP_DASH;
                    inv_l = 1'b1;
                    if (it.key_set)
                    begin
                        inv_l = 1'b0;
                        pg    = PAGE_SET_DAY;
                    end
                    mo = 4'(bump(mo, it.key_plus, it.key_minus, FIELD_ONE, MONTH_MAX));
                end
                PAGE_SET_DAY:
                begin
                    sep   = SEP_DASH;
                    inv_r = 1'b1;
                    if (it.key_set)
                    begin
                        inv_r = 1'b0;
                        pg    = PAGE_SET_HOUR;
                    end
                    dd = 5'(bump(dd, it.key_plus, it.key_minus, FIELD_ONE, DAY_MAX));
                end
                default:
                begin
                end
            endcase
        end
        r.page            = pg;
        r.show_hour       = hh;
        r.show_minute     = mi;
        r.show_year       = yy;
        r.show_month      = mo;
        r.show_day        = dd;
        r.show_week       = wk;
        r.separator       = sep;
        r.highlight_left  = inv_l;
        r.highlight_right = inv_r;
        r.rtc_write       = wr;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bus packing (first field in the low bits)
    // ------------------------------------------------------------------
    function automatic logic [39:0] pack_item(in_item_t it);
        return {1'b0, it.rtc_week, it.rtc_day, it.rtc_month, it.rtc_year,
                it.rtc_second, it.rtc_minute, it.rtc_hour,
                it.key_minus, it.key_plus, it.key_set};
    endfunction

    function automatic result_t unpack_display(logic [39:0] d);
        result_t r;
        r.page            = d[3:0];
        r.show_hour       = d[8:4];
        r.show_minute     = d[14:9];
        r.show_year       = d[21:15];
        r.show_month      = d[25:22];
        r.show_day        = d[30:26];
        r.show_week       = d[33:31];
        r.separator       = d[35:34];
        r.highlight_left  = d[36];
        r.highlight_right = d[37];
        r.rtc_write       = d[38];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic log_mismatch(string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic cmp(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want)
            log_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // mostly in range with weight on the bounds, sometimes any bit pattern
    function automatic int pick(int lo, int hi, int width);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return lo;
        if (r < 4)
            return hi;
        if (r < 9)
            return $urandom_range(lo, hi);
        return $urandom_range(0, (1 << width) - 1);
    endfunction

    function automatic in_item_t new_reading();
        in_item_t it;
        int       s;
        it.cmd        = CMD_UI;
        it.key_set    = 1'b0;
        it.key_plus   = 1'b0;
        it.key_minus  = 1'b0;
        it.rtc_hour   = 5'(pick(0, 23, 5));
        it.rtc_minute = 6'(pick(0, 59, 6));
        it.rtc_year   = 7'(pick(0, 99, 7));
        it.rtc_month  = 4'(pick(1, 12, 4));
        it.rtc_day    = 5'(pick(1, 31, 5));
        it.rtc_week   = 3'($urandom_range(0, 7));
        // seconds land on a page turn often enough to walk the rotation
        s = $urandom_range(0, 9);
        case (s)
            0: it.rtc_second = SEC_TO_YEAR;
            1: it.rtc_second = SEC_TO_DATE;
            2: it.rtc_second = SEC_TO_WEEK;
            3: it.rtc_second = SEC_TO_TIME;
            default: it.rtc_second = 6'(pick(0, 59, 6));
        endcase
        return it;
    endfunction

    function automatic in_item_t keyed(in_item_t b, bit ks, bit kp, bit km);
        b.key_set   = ks;
        b.key_plus  = kp;
        b.key_minus = km;
        return b;
    endfunction

    // tick with random payload; the block must ignore everything but cmd
    function automatic in_item_t tick_item();
        in_item_t    it;
        logic [63:0] raw;
        raw    = {$urandom(), $urandom()};
        it     = in_item_t'(raw[39:0]);
        it.cmd = CMD_TICK;
        return it;
    endfunction

    function automatic in_item_t random_item();
        if ($urandom_range(0, 9) == 0)
            return tick_item();
        return keyed(new_reading(), $urandom_range(0, 99) < 15,
                     $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 10);
    endfunction

    task automatic push_item(in_item_t it);
        op_t o;
        o.is_cfg  = 1'b0;
        o.cfg_val = '0;
        o.item    = it;
        pending.push_back(o);
        item_count++;
    endtask

    task automatic push_cfg(logic [14:0] v);
        op_t o;
        o.is_cfg  = 1'b1;
        o.cfg_val = v;
        o.item    = '0;
        pending.push_back(o);
    endtask

    // set, then every edited field gets some plus/minus traffic and a set
    task automatic push_edit_pass();
        int n;
        int k;
        push_item(keyed(new_reading(), 1'b1, 1'b0, 1'b0));
        repeat (5)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
            begin
                k = $urandom_range(0, 4);
                push_item(keyed(new_reading(), 1'b0, k != 1 && k != 3, k >= 1 && k != 4));
            end
            push_item(keyed(new_reading(), 1'b1, $urandom_range(0, 2) == 0,
                            $urandom_range(0, 2) == 0));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: launches queued items and register writes at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive
        logic v_nx;
        logic c_nx;
        if (rst_n)
        begin
            calm = (cycle_count % 4000) >= 3000;
            // a pending transfer holds until its handshake
            v_nx = s_tvalid && !s_taken;
            c_nx = cfg_valid && !cfg_taken;
            if (!v_nx && !c_nx && pending.size() > 0)
            begin
                if (pending[0].is_cfg)
                begin
                    // register writes only with the pipeline drained
                    if (shown_due.size() == 0 && quiet >= SETTLE)
                    begin
                        c_nx = 1'b1;
                        cfg_data <= pending[0].cfg_val;
                        void'(pending.pop_front());
                    end
                end
                else if (calm || $urandom_range(0, 99) >= IDLE_PCT)
                begin
                    v_nx = 1'b1;
                    s_tdata  <= pack_item(pending[0].item);
                    s_tuser  <= pending[0].item.cmd;
                    cur_item <= pending[0].item;
                    void'(pending.pop_front());
                end
            end
            s_tvalid  <= v_nx;
            cfg_valid <= c_nx;
            m_tready  <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts at input transfers, checks at output transfers
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        result_t want;
        result_t got;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("end of test: mismatches");
                $finish;
            end
            else
            begin
                if (cfg_valid && cfg_ready)
                begin
                    // a write reloads the countdown as well
                    boot_left = cfg_data;
                end
                if (s_tvalid && s_tready)
                    shown_due.push_back(next_display(cur_item));
                if (m_tvalid && m_tready)
                begin
                    got = unpack_display(m_tdata);
                    if (shown_due.size() == 0)
                        log_mismatch($sformatf("display transfer with none due: %h", m_tdata));
                    else
                    begin
                        want = shown_due.pop_front();
                        cmp("page", 7'(want.page), 7'(got.page));
                        cmp("show_hour", 7'(want.show_hour), 7'(got.show_hour));
                        cmp("show_minute", 7'(want.show_minute), 7'(got.show_minute));
                        cmp("show_year", want.show_year, got.show_year);
                        cmp("show_month", 7'(want.show_month), 7'(got.show_month));
                        cmp("show_day", 7'(want.show_day), 7'(got.show_day));
                        cmp("show_week", 7'(want.show_week), 7'(got.show_week));
                        cmp("separator", 7'(want.separator), 7'(got.separator));
                        cmp("highlight_left", 7'(want.highlight_left),
                            7'(got.highlight_left));
                        cmp("highlight_right", 7'(want.highlight_right),
                            7'(got.highlight_right));
                        cmp("rtc_write", 7'(want.rtc_write), 7'(got.rtc_write));
                    end
                end
                s_taken   <= s_tvalid && s_tready;
                cfg_taken <= cfg_valid && cfg_ready;
                quiet     <= (shown_due.size() == 0 && !s_tvalid) ? quiet + 1 : 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, fill the stimulus queue, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin : sequence_main
        in_item_t rd;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // start-up screen at the reset length: nothing leaves it
        rd.cmd        = CMD_UI;
        rd.key_set    = 1'b0;
        rd.key_plus   = 1'b0;
        rd.key_minus  = 1'b0;
        rd.rtc_hour   = 5'd12;
        rd.rtc_minute = 6'd34;
        rd.rtc_second = 6'd4;
        rd.rtc_year   = 7'd24;
        rd.rtc_month  = 4'd6;
        rd.rtc_day    = 5'd15;
        rd.rtc_week   = 3'd3;
        push_item(rd);
        push_item(tick_item());

        // longest start-up: keys are ignored on the start-up page
        push_cfg(15'h7FFF);
        push_item(tick_item());
        push_item(keyed(rd, 1'b1, 1'b1, 1'b1));

        // short start-up: count down to zero, stay there, then time page
        push_cfg(15'd2);
        push_item(tick_item());
        push_item(rd);
        push_item(tick_item());
        push_item(tick_item());
        push_item(rd);

        // page rotation on the seconds value, colon on even seconds
        push_item(rd);
        rd.rtc_second = SEC_TO_YEAR;
        push_item(rd);
        rd.rtc_second = SEC_TO_DATE;
        push_item(rd);
        rd.rtc_second = SEC_TO_WEEK;
        push_item(rd);
        rd.rtc_second = SEC_TO_TIME;
        push_item(rd);
        // seconds rule beats the set key
        rd.rtc_second = SEC_TO_YEAR;
        push_item(keyed(rd, 1'b1, 1'b0, 1'b0));
        // minus wins over set -> blank; plus leaves blank; odd second, no colon
        rd.rtc_second = 6'd7;
        push_item(keyed(rd, 1'b1, 1'b0, 1'b1));
        push_item(keyed(rd, 1'b0, 1'b1, 1'b0));
        push_item(rd);

        // edit pass on a reading that is out of range everywhere
        rd.rtc_hour   = 5'd31;
        rd.rtc_minute = 6'd63;
        rd.rtc_second = 6'd6;
        rd.rtc_year   = 7'd127;
        rd.rtc_month  = 4'd15;
        rd.rtc_day    = 5'd0;
        rd.rtc_week   = 3'd7;
        push_item(keyed(rd, 1'b1, 1'b0, 1'b0));
        push_item(keyed(rd, 1'b0, 1'b1, 1'b1));   // year: plus blocked, minus
        push_item(keyed(rd, 1'b1, 1'b0, 1'b0));
        push_item(keyed(rd, 1'b0, 1'b0, 1'b1));   // month above bound, minus
        push_item(keyed(rd, 1'b1, 1'b0, 1'b0));
        push_item(keyed(rd, 1'b0, 1'b1, 1'b0));   // day zero, plus
        push_item(keyed(rd, 1'b1, 1'b0, 1'b0));
        push_item(keyed(rd, 1'b0, 1'b1, 1'b0));   // hour above bound, plus held
        push_item(keyed(rd, 1'b1, 1'b0, 1'b0));
        push_item(keyed(rd, 1'b0, 1'b0, 1'b1));   // minute minus
        push_item(keyed(rd, 1'b1, 1'b1, 1'b1));   // leave: write, keys ignored

        // random part, one chunk per register setting
        for (int c = 0; c < 4; c++)
        begin
            case (c)
                1: push_cfg(15'd0);
                2: push_cfg(15'h7FFF);
                3: push_cfg(15'($urandom_range(0, 32767)));
                default:
                begin
                end
            endcase
            item_count = 0;
            while (item_count < CHUNK_ITEMS)
            begin
                if ($urandom_range(0, 1) == 0)
                    push_edit_pass();
                else
                    push_item(random_item());
            end
        end

        // drain, then give any stray transfer time to show up
        while (pending.size() != 0 || s_tvalid || cfg_valid || shown_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE * 2) @(negedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
